// File: rtl/tcw_pkg.sv
// Shared codes, widths and the result record of the text console cursor writer.
package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    // Row that the cursor starts on after reset on a screen that is tall enough.
    localparam int HOME_ROW = 3;

    // Widths of the coordinate fields on the result channel.
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Control codes of the character stream.
    localparam logic [7:0] CODE_ATTR      = 8'd1;
    localparam logic [7:0] CODE_SAVE      = 8'd2;
    localparam logic [7:0] CODE_RESTORE   = 8'd3;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_LINEFEED  = 8'd10;
    localparam logic [7:0] CODE_RETURN    = 8'd13;

    // One result item as it travels through the output stages.
    typedef struct packed {
        logic                 cell_write;
        logic [ROW_OUT_W-1:0] cell_row;
        logic [COL_OUT_W-1:0] cell_col;
        logic [7:0]           cell_char;
        logic [7:0]           cell_attr;
        logic                 screen_scroll;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
    } result_t;

endpackage

// File: rtl/text_console_cursor_writer.sv
// Text console cursor writer: cursor, attribute and control-code handling per byte.
//
//  channel | direction | ports
//  --------+-----------+-------------------------------------------------------------
//  s_      | in        | s_valid, s_ready, s_char_code
//  m_      | out       | m_valid, m_ready, m_cell_write .. m_cursor_col (one per byte)
//
// Each accepted byte updates the cursor state in the cycle of its transfer and its
// result is registered; one byte can be taken per cycle while the skid entry is empty.
// The output register is backed by a one-entry skid register, so s_ready is a flop
// and a byte is still taken while one finished result waits on a stalled m_ channel.
// aresetn is synchronous and active low; it empties both output stages and puts the
// cursor and saved position on the home row, column 0, with attribute 1.
module text_console_cursor_writer
    import tcw_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_code,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_cell_write,
    output logic [ROW_OUT_W-1:0] m_cell_row,
    output logic [COL_OUT_W-1:0] m_cell_col,
    output logic [7:0]           m_cell_char,
    output logic [7:0]           m_cell_attr,
    output logic                 m_screen_scroll,
    output logic [ROW_OUT_W-1:0] m_cursor_row,
    output logic [COL_OUT_W-1:0] m_cursor_col
);

    localparam int RowW = $clog2(ROWS);
    localparam int ColW = $clog2(COLS);
    localparam int HomeRowInt = (HOME_ROW < ROWS - 1) ? HOME_ROW : ROWS - 1;
    localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);
    localparam logic [ColW-1:0] LastCol = ColW'(COLS - 1);
    localparam logic [RowW-1:0] HomeRow = RowW'(HomeRowInt);

    // Cursor state.
    logic [RowW-1:0] row_reg, row_next;
    logic [ColW-1:0] col_reg, col_next;
    logic [RowW-1:0] saved_row_reg, saved_row_next;
    logic [ColW-1:0] saved_col_reg, saved_col_next;
    logic [7:0]      attr_reg, attr_next;
    logic            expect_attr_reg, expect_attr_next;

    // Output stage and skid stage.
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    s_fire;
    logic    out_free;
    result_t res;
    logic    scroll;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Decode one byte against the current state.
    always_comb begin
        row_next         = row_reg;
        col_next         = col_reg;
        saved_row_next   = saved_row_reg;
        saved_col_next   = saved_col_reg;
        attr_next        = attr_reg;
        expect_attr_next = expect_attr_reg;
        scroll           = 1'b0;
        res              = '0;

        if (expect_attr_reg) begin
            attr_next        = s_char_code;
            expect_attr_next = 1'b0;
        end else begin
            unique case (s_char_code)
                CODE_ATTR: begin
                    expect_attr_next = 1'b1;
                end
                CODE_SAVE: begin
                    saved_row_next = row_reg;
                    saved_col_next = col_reg;
                end
                CODE_RESTORE: begin
                    row_next = saved_row_reg;
                    col_next = saved_col_reg;
                end
                CODE_BACKSPACE: begin
                    if (col_reg != '0) begin
                        col_next = col_reg - ColW'(1);
                    end
                end
                CODE_RETURN: begin
                    col_next = '0;
                end
                CODE_LINEFEED: begin
                    col_next = '0;
                    if (row_reg == LastRow) begin
                        scroll = 1'b1;
                    end else begin
                        row_next = row_reg + RowW'(1);
                    end
                end
                default: begin
                    res.cell_write = 1'b1;
                    res.cell_row   = ROW_OUT_W'(row_reg);
                    res.cell_col   = COL_OUT_W'(col_reg);
                    res.cell_char  = s_char_code;
                    res.cell_attr  = attr_reg;
                    // Wrap to the next line at the end of a row.
                    if (col_reg == LastCol) begin
                        col_next = '0;
                        if (row_reg == LastRow) begin
                            scroll = 1'b1;
                        end else begin
                            row_next = row_reg + RowW'(1);
                        end
                    end else begin
                        col_next = col_reg + ColW'(1);
                    end
                end
            endcase
        end

        res.screen_scroll = scroll;
        res.cursor_row    = ROW_OUT_W'(row_next);
        res.cursor_col    = COL_OUT_W'(col_next);
    end

    // State update on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg         <= HomeRow;
            col_reg         <= '0;
            saved_row_reg   <= HomeRow;
            saved_col_reg   <= '0;
            attr_reg        <= 8'd1;
            expect_attr_reg <= 1'b0;
        end else if (s_fire) begin
            row_reg         <= row_next;
            col_reg         <= col_next;
            saved_row_reg   <= saved_row_next;
            saved_col_reg   <= saved_col_next;
            attr_reg        <= attr_next;
            expect_attr_reg <= expect_attr_next;
        end
    end

    // Output register with skid entry; the skid entry drains first to keep order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (s_fire) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (s_fire) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_cell_write    = out_reg.cell_write;
    assign m_cell_row      = out_reg.cell_row;
    assign m_cell_col      = out_reg.cell_col;
    assign m_cell_char     = out_reg.cell_char;
    assign m_cell_attr     = out_reg.cell_attr;
    assign m_screen_scroll = out_reg.screen_scroll;
    assign m_cursor_row    = out_reg.cursor_row;
    assign m_cursor_col    = out_reg.cursor_col;

endmodule

// File: test/text_console_cursor_writer_tb.sv
// Self-checking testbench for the text console cursor writer.
module text_console_cursor_writer_tb
    import tcw_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 700;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_char_code = 8'd0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_cell_write;
    logic [ROW_OUT_W-1:0] m_cell_row;
    logic [COL_OUT_W-1:0] m_cell_col;
    logic [7:0]           m_cell_char;
    logic [7:0]           m_cell_attr;
    logic                 m_screen_scroll;
    logic [ROW_OUT_W-1:0] m_cursor_row;
    logic [COL_OUT_W-1:0] m_cursor_col;

    // Screen state as the testbench tracks it; starts at the home position.
    int unsigned cur_row = (HOME_ROW < DEF_ROWS - 1) ? HOME_ROW : DEF_ROWS - 1;
    int unsigned cur_col = 0;
    int unsigned mark_row = (HOME_ROW < DEF_ROWS - 1) ? HOME_ROW : DEF_ROWS - 1;
    int unsigned mark_col = 0;
    logic [7:0]  cur_attr = 8'd1;
    bit          attr_pending = 1'b0;

    result_t expected_cells[$];
    int      mismatches = 0;
    int      sent_items = 0;
    int      cycles = 0;
    bit      steady = 1'b0;

    text_console_cursor_writer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_write    (m_cell_write),
        .m_cell_row      (m_cell_row),
        .m_cell_col      (m_cell_col),
        .m_cell_char     (m_cell_char),
        .m_cell_attr     (m_cell_attr),
        .m_screen_scroll (m_screen_scroll),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_col    (m_cursor_col)
    );

    always #5 aclk = ~aclk;

    // Stop a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** text_console_cursor_writer: FAILED **");
            $finish;
        end
    end

    // The result side stalls at random except during the steady stretch.
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 15);
    end

    // Move to column 0 of the next row; returns 1 when the screen has to scroll.
    function automatic bit advance_line();
        cur_col = 0;
        if (cur_row + 1 >= DEF_ROWS) begin
            cur_row = DEF_ROWS - 1;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    // Apply one byte to the tracked screen state and return the result it causes.
    function automatic result_t next_cursor_result(input logic [7:0] code);
        result_t r;
        r = '0;
        if (attr_pending) begin
            cur_attr = code;
            attr_pending = 1'b0;
        end else if (code == CODE_ATTR) begin
            attr_pending = 1'b1;
        end else if (code == CODE_SAVE) begin
            mark_row = cur_row;
            mark_col = cur_col;
        end else if (code == CODE_RESTORE) begin
            cur_row = mark_row;
            cur_col = mark_col;
        end else if (code == CODE_BACKSPACE) begin
            if (cur_col > 0)
                cur_col--;
        end else if (code == CODE_RETURN) begin
            cur_col = 0;
        end else if (code == CODE_LINEFEED) begin
            r.screen_scroll = advance_line();
        end else begin
            r.cell_write = 1'b1;
            r.cell_row   = cur_row[ROW_OUT_W-1:0];
            r.cell_col   = cur_col[COL_OUT_W-1:0];
            r.cell_char  = code;
            r.cell_attr  = cur_attr;
            if (cur_col + 1 >= DEF_COLS)
                r.screen_scroll = advance_line();
            else
                cur_col++;
        end
        r.cursor_row = cur_row[ROW_OUT_W-1:0];
        r.cursor_col = cur_col[COL_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 50)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // Compare each result transfer with the oldest expected result.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 0);
            end else begin
                want = expected_cells.pop_front();
                if (m_cell_write != want.cell_write)
                    report_mismatch("cell_write", m_cell_write, want.cell_write);
                if (m_cell_row != want.cell_row)
                    report_mismatch("cell_row", m_cell_row, want.cell_row);
                if (m_cell_col != want.cell_col)
                    report_mismatch("cell_col", m_cell_col, want.cell_col);
                if (m_cell_char != want.cell_char)
                    report_mismatch("cell_char", m_cell_char, want.cell_char);
                if (m_cell_attr != want.cell_attr)
                    report_mismatch("cell_attr", m_cell_attr, want.cell_attr);
                if (m_screen_scroll != want.screen_scroll)
                    report_mismatch("screen_scroll", m_screen_scroll, want.screen_scroll);
                if (m_cursor_row != want.cursor_row)
                    report_mismatch("cursor_row", m_cursor_row, want.cursor_row);
                if (m_cursor_col != want.cursor_col)
                    report_mismatch("cursor_col", m_cursor_col, want.cursor_col);
            end
        end
    end

    // Send one byte. Entered and left just after a falling edge; valid stays high
    // between back-to-back bytes.
    task automatic send_char(input logic [7:0] code);
        if (!steady && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        expected_cells.push_back(next_cursor_result(code));
        sent_items++;
        @(negedge aclk);
    endtask

    function automatic bit is_control(input logic [7:0] code);
        return code inside {CODE_ATTR, CODE_SAVE, CODE_RESTORE,
                            CODE_BACKSPACE, CODE_LINEFEED, CODE_RETURN};
    endfunction

    function automatic logic [7:0] random_text_char();
        logic [7:0] code;
        do code = 8'($urandom_range(255)); while (is_control(code));
        return code;
    endfunction

    // A restore before any save goes back to the home position.
    task automatic test_restore_before_save();
        send_char(CODE_RESTORE);
    endtask

    // Cells with the extreme and alternating byte values.
    task automatic test_cell_extremes();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h55);
        send_char(8'hAA);
    endtask

    // Backspace, return, backspace at column zero, save, a cell, line feed and restore.
    task automatic test_control_codes();
        send_char(CODE_BACKSPACE);
        send_char(CODE_RETURN);
        send_char(CODE_BACKSPACE);
        send_char(CODE_SAVE);
        send_char("x");
        send_char(CODE_LINEFEED);
        send_char(CODE_RESTORE);
    endtask

    // The byte after the attribute code is always taken as the attribute,
    // even when it is itself a control code.
    task automatic test_attribute_bytes();
        send_char(CODE_ATTR);
        send_char(8'hFF);
        send_char("Z");
        send_char(CODE_ATTR);
        send_char(CODE_ATTR);
        send_char(CODE_ATTR);
        send_char(8'h00);
        send_char("q");
    endtask

    // Mostly text lines with line ends, so that rows wrap and the screen scrolls,
    // mixed with attribute changes, save and restore, backspaces and noise.
    task automatic test_random_stream(input int count);
        int first;
        int kind;
        int len;
        first = sent_items;
        while (sent_items - first < count) begin
            steady = (sent_items - first >= 250) && (sent_items - first < 400);
            kind = $urandom_range(99);
            if (kind < 50) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 40);
                repeat (len) send_char(random_text_char());
                kind = $urandom_range(9);
                if (kind < 5) begin
                    send_char(CODE_RETURN);
                    send_char(CODE_LINEFEED);
                end else if (kind < 8) begin
                    send_char(CODE_LINEFEED);
                end
            end else if (kind < 62) begin
                send_char(CODE_ATTR);
                send_char(8'($urandom_range(255)));
            end else if (kind < 72) begin
                send_char(CODE_SAVE);
                repeat ($urandom_range(0, 10)) send_char(random_text_char());
                send_char(CODE_RESTORE);
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 5)) send_char(CODE_BACKSPACE);
            end else begin
                repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_restore_before_save();
        test_cell_extremes();
        test_control_codes();
        test_attribute_bytes();
        test_random_stream(RANDOM_ITEMS);

        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("** text_console_cursor_writer: PASSED **");
        else
            $display("** text_console_cursor_writer: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tcw_pkg.sv
rtl/text_console_cursor_writer.sv
test/text_console_cursor_writer_tb.sv
